FILE: rtl/nls_pkg.sv
package nls_pkg;

  localparam int unsigned NumW   = 31;
  localparam int unsigned CntW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [NumW-1:0] NumMax = {NumW{1'b1}};
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChNul     = 8'h00;

  localparam logic [CfgIdxW-1:0] RegRangeFirst = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRangeLast  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTargetLine = 2'd2;

  // byte class as seen by the line parser
  typedef enum logic [2:0] {
    KindEnd,
    KindNewline,
    KindSpace,
    KindTab,
    KindDigit,
    KindCr,
    KindOther
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic full;
  } q_ctl_t;

endpackage

FILE: rtl/nls_if.sv
interface nls_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;

  modport source (output valid, output mode, output char_byte, input ready);
  modport sink   (input valid, input mode, input char_byte, output ready);
endinterface

interface nls_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] line_number;
  logic [15:0] text_start;
  logic [15:0] text_len;
  logic [15:0] line_index;
  logic        in_range;
  logic        matches_target;
  logic [15:0] range_count;
  logic [15:0] line_count;
  logic        ends_source;

  modport source (
    output valid, output line_number, output text_start, output text_len,
    output line_index, output in_range, output matches_target,
    output range_count, output line_count, output ends_source,
    input ready
  );
  modport sink (
    input valid, input line_number, input text_start, input text_len,
    input line_index, input in_range, input matches_target,
    input range_count, input line_count, input ends_source,
    output ready
  );
endinterface

interface nls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/nls_front.sv
module nls_front (
  nls_in_if.sink         in_ch,
  input  nls_pkg::q_ctl_t ctl_i,
  output logic           push_o,
  output nls_pkg::item_t item_o
);

  logic [7:0] c;

  assign c           = in_ch.char_byte;
  assign in_ch.ready = !ctl_i.full;
  assign push_o      = in_ch.valid && !ctl_i.full;

  always_comb begin
    item_o.digit = 4'(c - nls_pkg::ChZero);
    if (in_ch.mode || c == nls_pkg::ChNul) begin
      item_o.kind = nls_pkg::KindEnd;
    end else if (c == nls_pkg::ChNewline) begin
      item_o.kind = nls_pkg::KindNewline;
    end else if (c == nls_pkg::ChSpace) begin
      item_o.kind = nls_pkg::KindSpace;
    end else if (c == nls_pkg::ChTab) begin
      item_o.kind = nls_pkg::KindTab;
    end else if (c >= nls_pkg::ChZero && c <= nls_pkg::ChNine) begin
      item_o.kind = nls_pkg::KindDigit;
    end else if (c == nls_pkg::ChCr) begin
      item_o.kind = nls_pkg::KindCr;
    end else begin
      item_o.kind = nls_pkg::KindOther;
    end
  end

endmodule

FILE: rtl/nls_queue.sv
module nls_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nls_pkg::item_t item_i,
  output nls_pkg::q_ctl_t ctl_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nls_pkg::item_t item_o
);

  nls_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign valid_o    = count_q != 2'd0;
  assign item_o     = mem_q[rd_ptr_q];
  assign ctl_o.full = count_q == 2'd2;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/nls_back.sv
module nls_back #(
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  nls_cfg_if.sink        cfg_ch,
  input  logic           q_valid_i,
  input  nls_pkg::item_t q_item_i,
  output logic           pop_o,
  nls_out_if.source      out_ch
);

  localparam int unsigned OffLimitInt =
    (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
  localparam logic [nls_pkg::CntW-1:0] OffLimit = nls_pkg::CntW'(OffLimitInt);

  localparam logic [2:0] PhLead   = 3'd0;
  localparam logic [2:0] PhDigits = 3'd1;
  localparam logic [2:0] PhSkip   = 3'd2;
  localparam logic [2:0] PhText   = 3'd3;
  localparam logic [2:0] PhIgnore = 3'd4;

  logic [30:0] range_first_q, range_last_q, target_line_q;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  space_count_q, space_count_d;
  logic [30:0] accum_q, accum_d;
  logic [15:0] byte_off_q, byte_off_d;
  logic [15:0] text_off_q, text_off_d;
  logic        prev_cr_q, prev_cr_d;
  logic [15:0] phys_line_q, phys_line_d;
  logic [15:0] num_total_q, num_total_d;
  logic [15:0] rng_total_q, rng_total_d;

  logic        out_valid_q, out_valid_d;
  logic [30:0] o_number_q;
  logic [15:0] o_start_q, o_len_q, o_line_q, o_rcnt_q, o_lcnt_q;
  logic        o_inr_q, o_match_q, o_end_q;

  logic        finish, numbered, emit, is_blank;
  logic [15:0] rec_start, rec_len, diff;
  logic        inr, match;
  logic [34:0] mul10;
  logic [15:0] off_inc;
  logic [15:0] num_total_inc, rng_total_inc;

  assign cfg_ch.ready = 1'b1;

  assign pop_o = q_valid_i && (!out_valid_q || out_ch.ready);

  assign finish   = q_item_i.kind == nls_pkg::KindEnd || q_item_i.kind == nls_pkg::KindNewline;
  assign numbered = phase_q == PhDigits || phase_q == PhSkip || phase_q == PhText;
  assign emit     = pop_o && finish && numbered;
  assign is_blank = q_item_i.kind == nls_pkg::KindSpace || q_item_i.kind == nls_pkg::KindTab;

  assign diff  = byte_off_q - text_off_q;
  assign inr   = accum_q >= range_first_q && accum_q <= range_last_q;
  assign match = accum_q == target_line_q;
  // accum * 10 as (x << 3) + (x << 1), plus the new digit
  assign mul10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {31'd0, q_item_i.digit};
  assign off_inc = (byte_off_q < OffLimit) ? byte_off_q + 16'd1 : byte_off_q;

  // totals including the record being emitted; the record carries these
  // even when end of source clears the totals afterwards
  assign num_total_inc = (emit && num_total_q != nls_pkg::CntMax) ?
                         num_total_q + 16'd1 : num_total_q;
  assign rng_total_inc = (emit && inr && rng_total_q != nls_pkg::CntMax) ?
                         rng_total_q + 16'd1 : rng_total_q;

  always_comb begin
    if (phase_q == PhText) begin
      rec_start = text_off_q;
      rec_len   = (byte_off_q >= text_off_q) ? diff : 16'd0;
      if (rec_len != 16'd0 && prev_cr_q) begin
        rec_len = rec_len - 16'd1;
      end
    end else begin
      rec_start = byte_off_q;
      rec_len   = 16'd0;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    space_count_d = space_count_q;
    accum_d       = accum_q;
    byte_off_d    = byte_off_q;
    text_off_d    = text_off_q;
    prev_cr_d     = prev_cr_q;
    phys_line_d   = phys_line_q;
    num_total_d   = num_total_inc;
    rng_total_d   = rng_total_inc;

    if (pop_o) begin
      case (q_item_i.kind)
        nls_pkg::KindEnd: begin
          phase_d       = PhLead;
          space_count_d = 2'd0;
          accum_d       = '0;
          byte_off_d    = '0;
          text_off_d    = '0;
          prev_cr_d     = 1'b0;
          phys_line_d   = 16'd1;
          num_total_d   = '0;
          rng_total_d   = '0;
        end
        nls_pkg::KindNewline: begin
          phase_d       = PhLead;
          space_count_d = 2'd0;
          accum_d       = '0;
          prev_cr_d     = 1'b0;
          byte_off_d    = off_inc;
          if (phys_line_q != nls_pkg::CntMax) begin
            phys_line_d = phys_line_q + 16'd1;
          end
        end
        default: begin
          byte_off_d = off_inc;
          case (phase_q)
            PhLead: begin
              if (q_item_i.kind == nls_pkg::KindSpace) begin
                if (space_count_q != 2'd2) begin
                  space_count_d = space_count_q + 2'd1;
                end
              end else if (q_item_i.kind == nls_pkg::KindDigit && space_count_q <= 2'd1) begin
                phase_d = PhDigits;
                accum_d = {27'd0, q_item_i.digit};
              end else begin
                phase_d = PhIgnore;
              end
            end
            PhDigits: begin
              if (q_item_i.kind == nls_pkg::KindDigit) begin
                accum_d = (mul10 > {4'd0, nls_pkg::NumMax}) ? nls_pkg::NumMax : mul10[30:0];
              end else if (is_blank) begin
                phase_d = PhSkip;
              end else begin
                phase_d    = PhText;
                text_off_d = byte_off_q;
                prev_cr_d  = q_item_i.kind == nls_pkg::KindCr;
              end
            end
            PhSkip: begin
              if (!is_blank) begin
                phase_d    = PhText;
                text_off_d = byte_off_q;
                prev_cr_d  = q_item_i.kind == nls_pkg::KindCr;
              end
            end
            PhText: begin
              prev_cr_d = q_item_i.kind == nls_pkg::KindCr;
            end
            default: begin
              phase_d = PhIgnore;
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_first_q <= '0;
      range_last_q  <= nls_pkg::NumMax;
      target_line_q <= '0;
      phase_q       <= PhLead;
      space_count_q <= 2'd0;
      accum_q       <= '0;
      byte_off_q    <= '0;
      text_off_q    <= '0;
      prev_cr_q     <= 1'b0;
      phys_line_q   <= 16'd1;
      num_total_q   <= '0;
      rng_total_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          nls_pkg::RegRangeFirst: range_first_q <= cfg_ch.data;
          nls_pkg::RegRangeLast:  range_last_q  <= cfg_ch.data;
          nls_pkg::RegTargetLine: target_line_q <= cfg_ch.data;
          default: ;
        endcase
      end
      phase_q       <= phase_d;
      space_count_q <= space_count_d;
      accum_q       <= accum_d;
      byte_off_q    <= byte_off_d;
      text_off_q    <= text_off_d;
      prev_cr_q     <= prev_cr_d;
      phys_line_q   <= phys_line_d;
      num_total_q   <= num_total_d;
      rng_total_q   <= rng_total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_number_q <= accum_q;
      o_start_q  <= rec_start;
      o_len_q    <= rec_len;
      o_line_q   <= phys_line_q;
      o_inr_q    <= inr;
      o_match_q  <= match;
      o_rcnt_q   <= rng_total_inc;
      o_lcnt_q   <= num_total_inc;
      o_end_q    <= q_item_i.kind == nls_pkg::KindEnd;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.line_number    = o_number_q;
  assign out_ch.text_start     = o_start_q;
  assign out_ch.text_len       = o_len_q;
  assign out_ch.line_index     = o_line_q;
  assign out_ch.in_range       = o_inr_q;
  assign out_ch.matches_target = o_match_q;
  assign out_ch.range_count    = o_rcnt_q;
  assign out_ch.line_count     = o_lcnt_q;
  assign out_ch.ends_source    = o_end_q;

endmodule

FILE: rtl/numbered_line_scanner.sv
// Channel  Dir  Payload                                   Transfer
// in_ch    in   mode, char_byte                           valid & ready
// out_ch   out  line_number .. ends_source (one record)   valid & ready
// cfg_ch   in   index (0 first, 1 last, 2 target), data   valid & ready (ready tied high)
//
// One byte per cycle sustained while out_ch accepts records; out_ch.valid for a record is
// registered: its terminating byte is written to the queue, then popped into parser + output register.
// Rate is set by the parser loop: phase, offsets and the x10 accumulator update once a cycle while bytes are popped.
// Reset clears the parser, counters, queue and output valid; config returns to defaults.
// A stalled output holds the record and every queued byte; the 2-entry queue fills,
// then in_ch.ready drops.
module numbered_line_scanner #(
  parameter int unsigned MAX_SOURCE_BYTES = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nls_in_if.sink    in_ch,
  nls_out_if.source out_ch,
  nls_cfg_if.sink   cfg_ch
);

  logic            push;
  nls_pkg::item_t  push_item;
  nls_pkg::q_ctl_t q_ctl;
  logic            pop;
  logic            q_valid;
  nls_pkg::item_t  q_item;

  nls_front u_front (
    .in_ch  (in_ch),
    .ctl_i  (q_ctl),
    .push_o (push),
    .item_o (push_item)
  );

  nls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ctl_o   (q_ctl),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  nls_back #(
    .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_ch    (cfg_ch),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule
